// ===== hdl/ddtn_pkg.sv =====
// Shared types, constants and the sine table of the dual DDS tone and noise burst generator.
// Depends on nothing; every other file in hdl imports this package.
`default_nettype none

package ddtn_pkg;

  // Oscillator geometry.
  localparam int TABLE_BITS = 8;
  localparam int PHASE_BITS = 16;
  localparam int FB_MULT    = 4;

  // The sine table itself always has 256 entries.
  localparam int ROM_AW    = 8;
  localparam int ROM_DEPTH = 1 << ROM_AW;

  localparam int RSH1 = (PHASE_BITS >= TABLE_BITS) ? (PHASE_BITS - TABLE_BITS) : 0;
  localparam int LSH1 = (TABLE_BITS > PHASE_BITS) ? (TABLE_BITS - PHASE_BITS) : 0;
  localparam int RSH2 = (TABLE_BITS >= ROM_AW) ? (TABLE_BITS - ROM_AW) : 0;
  localparam int LSH2 = (TABLE_BITS < ROM_AW) ? (ROM_AW - TABLE_BITS) : 0;
  localparam logic [31:0] TABLE_MASK = 32'((64'd1 << TABLE_BITS) - 64'd1);

  // Field widths of the stream payloads.
  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 56;

  // Item kinds.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_OFF   = 2'd2;
  localparam logic [1:0] MODE_BURST = 2'd3;

  // Sources.
  localparam logic [1:0] SRC_STIM  = 2'd0;
  localparam logic [1:0] SRC_FB    = 2'd1;
  localparam logic [1:0] SRC_NOISE = 2'd2;
  localparam logic [1:0] SRC_NONE  = 2'd3;

  // Bit positions in the channel enable vector.
  localparam int EN_STIM_R  = 0;
  localparam int EN_STIM_L  = 1;
  localparam int EN_FB_R    = 2;
  localparam int EN_FB_L    = 3;
  localparam int EN_NOISE_R = 4;
  localparam int EN_NOISE_L = 5;

  localparam logic [5:0]  EN_RESET  = 6'h0F;
  localparam logic [31:0] LFSR_SEED = 32'hFEEDFACE;
  localparam logic [31:0] LFSR_TAPS = 32'h80008006;
  localparam logic [7:0]  FB_IDLE   = 8'd117;
  localparam logic [7:0]  NOISE_HI  = 8'd129;
  localparam logic [7:0]  NOISE_LO  = 8'd125;

  typedef logic [PHASE_BITS-1:0] phase_t;

  // Write port of the burst start memory.
  typedef struct packed {
    logic        we;
    logic        addr;
    logic [31:0] data;
  } burst_wr_t;

  // Read request to the sine ROM, one address per oscillator.
  typedef struct packed {
    logic              en;
    logic [ROM_AW-1:0] addr_stim;
    logic [ROM_AW-1:0] addr_fb;
  } rom_rd_t;

  localparam logic [7:0] SINE_TABLE [ROM_DEPTH] = '{
    8'h80,8'h83,8'h86,8'h89,8'h8c,8'h8f,8'h92,8'h95,8'h98,8'h9c,8'h9f,8'ha2,8'ha5,8'ha8,8'hab,8'hae,
    8'hb0,8'hb3,8'hb6,8'hb9,8'hbc,8'hbf,8'hc1,8'hc4,8'hc7,8'hc9,8'hcc,8'hce,8'hd1,8'hd3,8'hd5,8'hd8,
    8'hda,8'hdc,8'hde,8'he0,8'he2,8'he4,8'he6,8'he8,8'hea,8'hec,8'hed,8'hef,8'hf0,8'hf2,8'hf3,8'hf5,
    8'hf6,8'hf7,8'hf8,8'hf9,8'hfa,8'hfb,8'hfc,8'hfc,8'hfd,8'hfe,8'hfe,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hfe,8'hfe,8'hfd,8'hfc,8'hfc,8'hfb,8'hfa,8'hf9,8'hf8,8'hf7,
    8'hf6,8'hf5,8'hf3,8'hf2,8'hf0,8'hef,8'hed,8'hec,8'hea,8'he8,8'he6,8'he4,8'he2,8'he0,8'hde,8'hdc,
    8'hda,8'hd8,8'hd5,8'hd3,8'hd1,8'hce,8'hcc,8'hc9,8'hc7,8'hc4,8'hc1,8'hbf,8'hbc,8'hb9,8'hb6,8'hb3,
    8'hb0,8'hae,8'hab,8'ha8,8'ha5,8'ha2,8'h9f,8'h9c,8'h98,8'h95,8'h92,8'h8f,8'h8c,8'h89,8'h86,8'h83,
    8'h80,8'h7c,8'h79,8'h76,8'h73,8'h70,8'h6d,8'h6a,8'h67,8'h63,8'h60,8'h5d,8'h5a,8'h57,8'h54,8'h51,
    8'h4f,8'h4c,8'h49,8'h46,8'h43,8'h40,8'h3e,8'h3b,8'h38,8'h36,8'h33,8'h31,8'h2e,8'h2c,8'h2a,8'h27,
    8'h25,8'h23,8'h21,8'h1f,8'h1d,8'h1b,8'h19,8'h17,8'h15,8'h13,8'h12,8'h10,8'h0f,8'h0d,8'h0c,8'h0a,
    8'h09,8'h08,8'h07,8'h06,8'h05,8'h04,8'h03,8'h03,8'h02,8'h01,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h02,8'h03,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,
    8'h09,8'h0a,8'h0c,8'h0d,8'h0f,8'h10,8'h12,8'h13,8'h15,8'h17,8'h19,8'h1b,8'h1d,8'h1f,8'h21,8'h23,
    8'h25,8'h27,8'h2a,8'h2c,8'h2e,8'h31,8'h33,8'h36,8'h38,8'h3b,8'h3e,8'h40,8'h43,8'h46,8'h49,8'h4c,
    8'h4f,8'h51,8'h54,8'h57,8'h5a,8'h5d,8'h60,8'h63,8'h67,8'h6a,8'h6d,8'h70,8'h73,8'h76,8'h79,8'h7c
  };

  // Top TABLE_BITS of the phase, scaled onto the 256-entry table.
  function automatic logic [ROM_AW-1:0] rom_addr(input phase_t phase);
    logic [31:0] idx;
    idx = ((32'(phase) >> RSH1) << LSH1) & TABLE_MASK;
    idx = (idx >> RSH2) << LSH2;
    return idx[ROM_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dual_dds_tone_noise_burst_gen.sv =====
// Top level of the dual DDS tone and noise burst generator.
// Depends on ddtn_pkg, ddtn_sine_rom and ddtn_burst_ram.
`default_nettype none

// Every transaction on the input stream yields exactly one transaction on the output stream.
// The block takes one transaction per clock cycle while the output stream is not stalled.
// The burst start memory is read at the edge that accepts the input; the item then waits
// in the execute stage holding register until the output register is free, then executes
// and loads the output register. The burst start of each source lives in a small memory
// with a registered read; an item executes after its read and writes the memory at the end
// of the cycle in which it executes, and a read issued at the same edge as that write is
// forwarded, so items follow each other with no bubbles. Sample ticks (mode 0) advance both
// phase accumulators and the noise LFSR and look up the sine ROM; the looked-up samples are
// shown by the next item, so the tone fields of every result carry the samples of the
// previous tick. The noise fields carry the noise duty after the item, and the burst flags
// their value after the item. Tone on, tone off and burst update items change the step
// sizes, the channel enables, the stored ground reading and the burst state only. The output
// stream is backed by one output register; input tready is low during reset, and otherwise
// falls only when that register holds an untaken result and the execute stage is full.
module dual_dds_tone_noise_burst_gen (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // left[0], right[1], freq[17:2], ground_level[27:18], now_time[59:28],
  // burst_period[75:60], burst_length[91:76], zero[95:92]
  input  wire logic [ddtn_pkg::IN_DATA_W-1:0]     s_tdata,
  // mode[1:0], source[3:2]
  input  wire logic [ddtn_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // stim_a[7:0], stim_b[15:8], fb_a[23:16], fb_b[31:24], noise_a[39:32],
  // noise_b[47:40], stim_burst_on[48], fb_burst_on[49], zero[55:50]
  output logic [ddtn_pkg::OUT_DATA_W-1:0]         m_tdata
);
  import ddtn_pkg::*;

  // Execute stage holding register.
  logic                 s1_valid;
  logic [IN_DATA_W-1:0] s1_data;
  logic [IN_USER_W-1:0] s1_user;

  logic in_acc;
  logic advance;

  // Unpacked fields of the item in the execute stage.
  logic [1:0]  mode;
  logic [1:0]  source;
  logic        left;
  logic        right;
  logic [15:0] freq;
  logic [9:0]  ground_level;
  logic [31:0] now_time;
  logic [15:0] burst_period;
  logic [15:0] burst_length;

  // Architectural state.
  phase_t      stim_phase, stim_step, fb_phase, fb_step;
  logic [31:0] lfsr;
  logic [7:0]  noise_a, noise_b;
  logic [5:0]  en;
  logic [9:0]  ground;
  logic [1:0]  burst_flag;

  // What the last tick saw, used to form the pending samples from the ROM data.
  logic [3:0]  snap_en;
  logic [7:0]  snap_gnd;

  // Next values.
  phase_t      stim_phase_next, stim_step_next, fb_phase_next, fb_step_next;
  logic [31:0] lfsr_next;
  logic [7:0]  noise_aux;
  logic [7:0]  noise_a_next, noise_b_next;
  logic [5:0]  en_next;
  logic [9:0]  ground_next;
  logic [1:0]  burst_flag_next;
  logic        do_on, do_off;
  logic        tick;

  logic [31:0] start_rd;
  logic [31:0] elapsed;
  burst_wr_t   bwr;
  rom_rd_t     rom_rd;
  logic [7:0]  rom_stim, rom_fb;

  logic [7:0]  stim_a, stim_b, fb_a, fb_b;

  assign in_acc   = s_tvalid && s_tready;
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!s1_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data <= s_tdata;
      s1_user <= s_tuser;
    end
  end

  assign mode         = s1_user[1:0];
  assign source       = s1_user[3:2];
  assign left         = s1_data[0];
  assign right        = s1_data[1];
  assign freq         = s1_data[17:2];
  assign ground_level = s1_data[27:18];
  assign now_time     = s1_data[59:28];
  assign burst_period = s1_data[75:60];
  assign burst_length = s1_data[91:76];

  // The burst start is read when the item is accepted, keyed by the low source bit.
  ddtn_burst_ram u_burst_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (s_tuser[2]),
    .rd_data (start_rd),
    .wr      (bwr)
  );

  assign elapsed = now_time - start_rd;
  assign tick    = (mode == MODE_TICK);

  always_comb begin
    stim_phase_next = stim_phase + stim_step;
    fb_phase_next   = fb_phase + fb_step;

    if (lfsr[0]) begin
      lfsr_next = (lfsr >> 1) ^ LFSR_TAPS;
      noise_aux = NOISE_HI;
    end else begin
      lfsr_next = lfsr >> 1;
      noise_aux = NOISE_LO;
    end
    noise_a_next = en[EN_NOISE_R] ? noise_aux : noise_a;
    noise_b_next = en[EN_NOISE_L] ? noise_aux : noise_b;

    en_next         = en;
    stim_step_next  = stim_step;
    fb_step_next    = fb_step;
    ground_next     = ground;
    burst_flag_next = burst_flag;
    do_on           = 1'b0;
    do_off          = 1'b0;
    bwr.we          = 1'b0;
    bwr.addr        = source[0];
    bwr.data        = now_time;

    case (mode)
      MODE_TICK: begin
      end
      MODE_ON: begin
        do_on = 1'b1;
      end
      MODE_OFF: begin
        do_off = 1'b1;
      end
      MODE_BURST: begin
        // Only stimulus and feedback run bursts. A burst starts only while its flag is clear
        // and ends only while it is set, so it cannot also end in the same update.
        if ((source == SRC_STIM) || (source == SRC_FB)) begin
          if ((elapsed > 32'(burst_period)) && !burst_flag[source[0]]) begin
            do_on                      = 1'b1;
            bwr.we                     = advance;
            burst_flag_next[source[0]] = 1'b1;
          end else if ((elapsed > 32'(burst_length)) && burst_flag[source[0]]) begin
            do_off                     = 1'b1;
            burst_flag_next[source[0]] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_on) begin
      case (source)
        SRC_STIM: begin
          stim_step_next     = PHASE_BITS'(freq);
          en_next[EN_STIM_R] = right;
          en_next[EN_STIM_L] = left;
        end
        SRC_FB: begin
          fb_step_next     = PHASE_BITS'(32'(FB_MULT) * 32'(freq));
          en_next[EN_FB_R] = right;
          en_next[EN_FB_L] = left;
        end
        SRC_NOISE: begin
          en_next[EN_NOISE_R] = right;
          en_next[EN_NOISE_L] = left;
        end
        default: begin
        end
      endcase
    end

    if (do_off) begin
      case (source)
        SRC_STIM: begin
          if (right) en_next[EN_STIM_R] = 1'b0;
          if (left) en_next[EN_STIM_L] = 1'b0;
          ground_next = ground_level;
        end
        SRC_FB: begin
          if (right) en_next[EN_FB_R] = 1'b0;
          if (left) en_next[EN_FB_L] = 1'b0;
          ground_next = ground_level;
        end
        SRC_NOISE: begin
          // Tone off on the noise source inverts the selection.
          en_next[EN_NOISE_R] = !right;
          en_next[EN_NOISE_L] = !left;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stim_phase <= '0;
      fb_phase   <= '0;
      stim_step  <= '0;
      fb_step    <= '0;
      lfsr       <= LFSR_SEED;
      noise_a    <= '0;
      noise_b    <= '0;
      en         <= EN_RESET;
      ground     <= '0;
      burst_flag <= '0;
      snap_en    <= 4'hF;
      snap_gnd   <= '0;
    end else if (advance) begin
      stim_step  <= stim_step_next;
      fb_step    <= fb_step_next;
      en         <= en_next;
      ground     <= ground_next;
      burst_flag <= burst_flag_next;
      if (tick) begin
        stim_phase <= stim_phase_next;
        fb_phase   <= fb_phase_next;
        lfsr       <= lfsr_next;
        noise_a    <= noise_a_next;
        noise_b    <= noise_b_next;
        snap_en    <= en[3:0];
        snap_gnd   <= ground[9:2];
      end
    end
  end

  // A tick looks up both oscillators at their advanced phases.
  assign rom_rd.en        = advance && tick;
  assign rom_rd.addr_stim = rom_addr(stim_phase_next);
  assign rom_rd.addr_fb   = rom_addr(fb_phase_next);

  ddtn_sine_rom u_sine_rom (
    .clk       (clk),
    .rst       (rst),
    .rd        (rom_rd),
    .data_stim (rom_stim),
    .data_fb   (rom_fb)
  );

  // Pending samples of the last tick. Note the feedback channels are crossed:
  // fb_a follows the left enable and fb_b the right one.
  assign stim_a = snap_en[EN_STIM_R] ? rom_stim : snap_gnd;
  assign stim_b = snap_en[EN_STIM_L] ? rom_stim : snap_gnd;
  assign fb_a   = snap_en[EN_FB_L] ? rom_fb : FB_IDLE;
  assign fb_b   = snap_en[EN_FB_R] ? rom_fb : FB_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'd0, burst_flag_next[1], burst_flag_next[0],
                  (tick ? noise_b_next : noise_b), (tick ? noise_a_next : noise_a),
                  fb_b, fb_a, stim_b, stim_a};
    end
  end

  // The Galois LFSR starts from a nonzero seed and must never fall into the all-zero state.
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (rst) lfsr != '0)
    else $error("noise LFSR reached zero");

  // A tick must capture the channel enables it saw for the pending samples.
  a_tick_snap: assert property (@(posedge clk) disable iff (rst)
    (advance && tick) |=> (snap_en == $past(en[3:0])))
    else $error("tick did not capture the tone enables");

  // A stimulus burst only starts together with a write of its start time.
  a_burst_start_wr: assert property (@(posedge clk) disable iff (rst)
    $rose(burst_flag[0]) |-> $past(bwr.we && (bwr.addr == 1'b0)))
    else $error("stimulus burst started without a start time write");

  // The execute stage never drops an item while the output is stalled.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("execute stage lost an item");

endmodule

`default_nettype wire

// ===== hdl/ddtn_sine_rom.sv =====
// Registered sine ROM with one read address per oscillator.
// Depends on ddtn_pkg for the table contents and the request type.
`default_nettype none

module ddtn_sine_rom (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ddtn_pkg::rom_rd_t rd,
  output logic [7:0]            data_stim,
  output logic [7:0]            data_fb
);
  import ddtn_pkg::*;

  // Both outputs start at zero so that the samples shown before the first tick are zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_stim <= '0;
      data_fb   <= '0;
    end else if (rd.en) begin
      data_stim <= SINE_TABLE[rd.addr_stim];
      data_fb   <= SINE_TABLE[rd.addr_fb];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ddtn_burst_ram.sv =====
// Two-entry burst start memory, one read and one write port, registered read data.
// Depends on ddtn_pkg for the write port type. Reads see a write of the same edge.
`default_nettype none

module ddtn_burst_ram (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rd_en,
  input  wire logic               rd_addr,
  output logic [31:0]             rd_data,
  input  wire ddtn_pkg::burst_wr_t wr
);
  import ddtn_pkg::*;

  logic [31:0] mem [2];
  logic [1:0]  valid;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Entries read as zero until first written.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.we) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.we && (wr.addr == rd_addr)) begin
        rd_data <= wr.data;
      end else if (valid[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

`default_nettype wire
